// File: src/ldcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldcr_pkg: shared types and constants of the latched day clock registers
// Request codes, register numbers, clock limits and the reciprocal constants
// used to split an elapsed second count into clock digits.
// ----------------------------------------------------------------------------
package ldcr_pkg;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_LATCH = 2'd3
    } ldcr_req_t;

    localparam int NUM_REGS = 5;

    localparam logic [2:0] REG_SEC  = 3'd0;
    localparam logic [2:0] REG_MIN  = 3'd1;
    localparam logic [2:0] REG_HOUR = 3'd2;
    localparam logic [2:0] REG_DAYL = 3'd3;
    localparam logic [2:0] REG_DAYH = 3'd4;

    localparam logic [7:0]  SEC_LIMIT  = 8'd60;
    localparam logic [7:0]  MIN_LIMIT  = 8'd60;
    localparam logic [7:0]  HOUR_LIMIT = 8'd24;
    localparam logic [16:0] DAY_MAX    = 17'd511;
    localparam logic [7:0]  LATCH_ON   = 8'h01;
    localparam logic [7:0]  DAY_CARRY  = 8'h80;
    localparam logic [7:0]  READ_ZERO  = 8'h00;

    // x / 15 = (x * MAGIC_DIV15) >> 35 and x / 3 = (x * MAGIC_DIV3) >> 33,
    // exact for every unsigned 32-bit x.
    localparam logic [31:0] MAGIC_DIV15 = 32'h8888_8889;
    localparam logic [31:0] MAGIC_DIV3  = 32'hAAAA_AAAB;

    // Request fields that travel with every item through the pipeline.
    typedef struct packed {
        ldcr_req_t  req;
        logic [2:0] idx;
        logic [7:0] data;
        logic       nonzero;
    } ldcr_item_t;

    // Clock digits of an elapsed count, as handed to the register stage.
    typedef struct packed {
        ldcr_item_t  item;
        logic [5:0]  sec_part;
        logic [5:0]  min_part;
        logic [7:0]  hours_lo;
        logic [15:0] days;
    } ldcr_split_t;

endpackage

// File: src/ldcr_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldcr_split: elapsed-second splitter pipeline
// Four registered stages that break a 32-bit second count into seconds,
// minutes, hours and days, with at most one reciprocal multiply per stage.
// ----------------------------------------------------------------------------
module ldcr_split (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ldcr_pkg::ldcr_item_t in_item,
    input  logic [31:0]          in_elapsed,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ldcr_pkg::ldcr_split_t out_split
);
    import ldcr_pkg::*;

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic        s1_ready, s2_ready, s3_ready, s4_ready;
    ldcr_item_t  s1_item_reg, s2_item_reg, s3_item_reg, s4_item_reg;

    logic [31:0] s1_e_reg;
    logic [7:0]  s2_e_lo_reg;
    logic [26:0] s2_q1_reg;
    logic [5:0]  s3_r1_reg;
    logic [20:0] s3_q2_reg;
    logic [7:0]  s3_q1_lo_reg;
    logic [5:0]  s4_r1_reg;
    logic [5:0]  s4_r2_reg;
    logic [7:0]  s4_q2_lo_reg;
    logic [15:0] s4_q3_reg;

    logic [61:0] q1_prod;
    logic [56:0] q2_prod;
    logic [49:0] q3_prod;
    logic [26:0] s1_q1_next;
    logic [20:0] s2_q2_next;
    logic [15:0] s3_q3_next;
    logic [7:0]  r1_wide;
    logic [7:0]  r2_wide;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // e / 60 = (e >> 2) / 15, and so on down the chain.
    assign q1_prod    = 62'(s1_e_reg[31:2]) * 62'(MAGIC_DIV15);
    assign s1_q1_next = q1_prod[61:35];
    assign q2_prod    = 57'(s2_q1_reg[26:2]) * 57'(MAGIC_DIV15);
    assign s2_q2_next = q2_prod[55:35];
    assign q3_prod    = 50'(s3_q2_reg[20:3]) * 50'(MAGIC_DIV3);
    assign s3_q3_next = q3_prod[48:33];

    // Remainders are below 60, so eight bits of the difference suffice.
    assign r1_wide = s2_e_lo_reg - 8'(s2_q1_reg[7:0] * SEC_LIMIT);
    assign r2_wide = s3_q1_lo_reg - 8'(s3_q2_reg[7:0] * MIN_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_item_reg <= in_item;
            s1_e_reg    <= in_elapsed;
        end
        if (s2_ready)
        begin
            s2_item_reg <= s1_item_reg;
            s2_e_lo_reg <= s1_e_reg[7:0];
            s2_q1_reg   <= s1_q1_next;
        end
        if (s3_ready)
        begin
            s3_item_reg  <= s2_item_reg;
            s3_r1_reg    <= r1_wide[5:0];
            s3_q2_reg    <= s2_q2_next;
            s3_q1_lo_reg <= s2_q1_reg[7:0];
        end
        if (s4_ready)
        begin
            s4_item_reg  <= s3_item_reg;
            s4_r1_reg    <= s3_r1_reg;
            s4_r2_reg    <= r2_wide[5:0];
            s4_q2_lo_reg <= s3_q2_reg[7:0];
            s4_q3_reg    <= s3_q3_next;
        end
    end

    assign out_valid          = s4_valid_reg;
    assign out_split.item     = s4_item_reg;
    assign out_split.sec_part = s4_r1_reg;
    assign out_split.min_part = s4_r2_reg;
    assign out_split.hours_lo = s4_q2_lo_reg;
    assign out_split.days     = s4_q3_reg;

endmodule

// File: src/latched_day_clock_registers_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latched_day_clock_registers_top: real-time clock behind five byte registers
// Seconds, minutes, hours and a 9-bit day count with a sticky overflow carry,
// advanced by tick beats, accessed by read and write beats, and copied into
// a latch by a latch-control beat.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  s_axis    in         one request beat: tick, read, write or latch control
//  m_axis    out        one read-data byte for every read request
//
//  One request beat is taken per clock cycle while s_axis_tready is high. A
//  read result passes through the four-stage splitter, with at most one
//  reciprocal multiply per stage, and then into the output register. Only
//  read beats produce a result, and they leave in request order. A stalled
//  output holds its byte; a read that reaches the end of the splitter then
//  waits there and holds up every beat behind it, and s_axis_tready drops
//  only when every stage is full. Reset clears all clock registers, the
//  latched copy and the latch flag.
//
module latched_day_clock_registers_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] reg_index, [10:3] write_data, [42:11] elapsed_seconds, [47:43] zero
    input  logic [47:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] read_data
    output logic [7:0]  m_axis_tdata
);
    import ldcr_pkg::*;

    ldcr_item_t  in_item;
    logic        sp_valid;
    logic        sp_ready;
    logic        sp_fire;
    ldcr_split_t sp;

    logic [7:0]  time_reg [NUM_REGS];
    logic [7:0]  time_next [NUM_REGS];
    logic [7:0]  latch_reg [NUM_REGS];
    logic        latch_flag_reg;
    logic        latch_flag_next;
    logic        copy_en;

    logic        out_valid_reg;
    logic [7:0]  out_data_reg;
    logic        out_free;
    logic [7:0]  read_byte;

    // Tick arithmetic on the live registers.
    logic [7:0]  sec_sum, min_sum, hour_sum;
    logic        sec_carry, min_carry, hour_carry;
    logic [7:0]  sec_new, min_new, hour_new;
    logic [7:0]  hour_part;
    logic [16:0] day_sum;
    logic [7:0]  dayh_new;

    assign in_item.req     = ldcr_req_t'(s_axis_tuser);
    assign in_item.idx     = s_axis_tdata[2:0];
    assign in_item.data    = s_axis_tdata[10:3];
    assign in_item.nonzero = |s_axis_tdata[42:11];

    ldcr_split u_split (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .in_elapsed (s_axis_tdata[42:11]),
        .out_valid  (sp_valid),
        .out_ready  (sp_ready),
        .out_split  (sp)
    );

    // A read needs room in the output register; everything else retires.
    assign out_free = !out_valid_reg || m_axis_tready;
    assign sp_ready = (sp.item.req != REQ_READ) || out_free;
    assign sp_fire  = sp_valid && sp_ready;

    // Hour digit is the low byte of e / 3600 reduced mod 24, under 24.
    assign hour_part = sp.hours_lo - 8'(sp.days[7:0] * HOUR_LIMIT);

    always_comb
    begin
        sec_sum    = time_reg[REG_SEC] + 8'(sp.sec_part);
        sec_carry  = sec_sum >= SEC_LIMIT;
        sec_new    = sec_carry ? sec_sum - SEC_LIMIT : sec_sum;

        min_sum    = time_reg[REG_MIN] + 8'(sec_carry) + 8'(sp.min_part);
        min_carry  = min_sum >= MIN_LIMIT;
        min_new    = min_carry ? min_sum - MIN_LIMIT : min_sum;

        hour_sum   = time_reg[REG_HOUR] + 8'(min_carry) + hour_part;
        hour_carry = hour_sum >= HOUR_LIMIT;
        hour_new   = hour_carry ? hour_sum - HOUR_LIMIT : hour_sum;

        day_sum    = 17'({time_reg[REG_DAYH][0], time_reg[REG_DAYL]}) + 17'(hour_carry)
                   + 17'(sp.days);
        dayh_new   = {time_reg[REG_DAYH][7:1], day_sum[8]};
        if (day_sum > DAY_MAX)
            dayh_new = dayh_new | DAY_CARRY;
    end

    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
            time_next[i] = time_reg[i];
        latch_flag_next = latch_flag_reg;
        copy_en         = 1'b0;
        if (sp_fire)
        begin
            unique case (sp.item.req)
                REQ_TICK:
                begin
                    // A zero count leaves even out-of-range values alone.
                    if (sp.item.nonzero)
                    begin
                        time_next[REG_SEC]  = sec_new;
                        time_next[REG_MIN]  = min_new;
                        time_next[REG_HOUR] = hour_new;
                        time_next[REG_DAYL] = day_sum[7:0];
                        time_next[REG_DAYH] = dayh_new;
                    end
                end
                REQ_READ:
                begin
                end
                REQ_WRITE:
                begin
                    if (sp.item.idx < 3'(NUM_REGS))
                        time_next[sp.item.idx] = sp.item.data;
                end
                REQ_LATCH:
                begin
                    copy_en         = !latch_flag_reg && (sp.item.data == LATCH_ON);
                    latch_flag_next = sp.item.data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (sp.item.idx >= 3'(NUM_REGS))
            read_byte = READ_ZERO;
        else if (latch_flag_reg)
            read_byte = latch_reg[sp.item.idx];
        else
            read_byte = time_reg[sp.item.idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                time_reg[i]  <= 8'h00;
                latch_reg[i] <= 8'h00;
            end
            latch_flag_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                time_reg[i] <= time_next[i];
                if (copy_en)
                    latch_reg[i] <= time_reg[i];
            end
            latch_flag_reg <= latch_flag_next;
            if (out_free)
                out_valid_reg <= sp_fire && (sp.item.req == REQ_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && sp_fire && (sp.item.req == REQ_READ))
            out_data_reg <= read_byte;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // The day overflow carry only clears through a write to register four.
    a_carry_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (time_reg[REG_DAYH][7] && !(sp_fire && sp.item.req == REQ_WRITE
            && sp.item.idx == REG_DAYH)) |=> time_reg[REG_DAYH][7])
        else $error("day overflow carry cleared without a register write");

    // An in-range seconds value stays in range across a tick.
    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sp_fire && sp.item.req == REQ_TICK && time_reg[REG_SEC] < SEC_LIMIT)
            |=> time_reg[REG_SEC] < SEC_LIMIT)
        else $error("seconds left range after a tick");

    // An in-range hours value stays in range across a tick.
    a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sp_fire && sp.item.req == REQ_TICK && time_reg[REG_HOUR] < HOUR_LIMIT)
            |=> time_reg[REG_HOUR] < HOUR_LIMIT)
        else $error("hours left range after a tick");

    // A result beat only appears after a read request has retired.
    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(sp_fire && sp.item.req == REQ_READ))
        else $error("result beat without a read request");

endmodule

// File: test/tb_latched_day_clock_registers_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_latched_day_clock_registers_top: self-checking bench for the clock block
// Drives tick, read, write and latch-control beats into the request stream.
// A scoreboard keeps its own copy of the clock registers, the latch and the
// latch flag. It predicts every read byte and compares it with the result
// stream, in order, while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_latched_day_clock_registers_top;

    import ldcr_pkg::*;

    localparam logic [7:0] LATCH_OFF = 8'h00;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_CYCLES  = 300;

    // ------------------------------------------------------------------------
    // Scoreboard: clock register model and the queue of expected read bytes.
    // ------------------------------------------------------------------------
    class ldcr_scoreboard;
        logic [7:0] live_regs [NUM_REGS];
        logic [7:0] held_regs [NUM_REGS];
        logic       held_valid;
        logic [7:0] expected_bytes [$];
        int errors;
        int n_ticks;
        int n_reads;
        int n_writes;
        int n_latches;
        int n_checked;
        int accepted;

        function new();
            for (int k = 0; k < NUM_REGS; k++)
            begin
                live_regs[k] = 8'h00;
                held_regs[k] = 8'h00;
            end
            held_valid = 1'b0;
        endfunction

        // Adds one clock digit; the sum wraps at 8 bits and drops by the
        // limit once when it reaches it. Returns the carry.
        function logic add_digit(input logic [7:0] field, input logic [31:0] part,
                                 input logic [7:0] limit, output logic [7:0] result);
            logic [31:0] sum;
            sum = ({24'd0, field} + part) & 32'h0000_00ff;
            if (sum >= {24'd0, limit})
            begin
                result = sum[7:0] - limit;
                return 1'b1;
            end
            result = sum[7:0];
            return 1'b0;
        endfunction

        function void advance_clock(input logic [31:0] secs);
            logic [31:0] rest;
            logic [31:0] days;
            logic        carry;
            if (secs == 32'd0)
                return;
            rest  = secs;
            carry = add_digit(live_regs[REG_SEC], rest % 60, SEC_LIMIT, live_regs[REG_SEC]);
            live_regs[REG_MIN] = live_regs[REG_MIN] + {7'd0, carry};
            rest  = rest / 60;
            carry = add_digit(live_regs[REG_MIN], rest % 60, MIN_LIMIT, live_regs[REG_MIN]);
            live_regs[REG_HOUR] = live_regs[REG_HOUR] + {7'd0, carry};
            rest  = rest / 60;
            carry = add_digit(live_regs[REG_HOUR], rest % 24, HOUR_LIMIT, live_regs[REG_HOUR]);
            rest  = rest / 24;
            // The day count is nine bits wide; the full sum decides the sticky carry.
            days = {23'd0, live_regs[REG_DAYH][0], live_regs[REG_DAYL]} + {31'd0, carry} + rest;
            live_regs[REG_DAYL]    = days[7:0];
            live_regs[REG_DAYH][0] = days[8];
            if (days > 32'd511)
                live_regs[REG_DAYH] = live_regs[REG_DAYH] | DAY_CARRY;
        endfunction

        // Called once per accepted request beat.
        function void note_request(input ldcr_req_t req, input logic [2:0] idx,
                                   input logic [7:0] data, input logic [31:0] secs);
            accepted++;
            case (req)
                REQ_TICK:
                begin
                    n_ticks++;
                    advance_clock(secs);
                end
                REQ_READ:
                begin
                    n_reads++;
                    if (idx >= NUM_REGS)
                        expected_bytes.push_back(READ_ZERO);
                    else if (held_valid)
                        expected_bytes.push_back(held_regs[idx]);
                    else
                        expected_bytes.push_back(live_regs[idx]);
                end
                REQ_WRITE:
                begin
                    n_writes++;
                    if (idx < NUM_REGS)
                        live_regs[idx] = data;
                end
                default:
                begin
                    n_latches++;
                    // Only a rising write of exactly one takes a snapshot.
                    if (!held_valid && data == LATCH_ON)
                        held_regs = live_regs;
                    held_valid = data[0];
                end
            endcase
        endfunction

        // Called once per accepted result beat.
        function void check_read(input logic [7:0] got);
            logic [7:0] want;
            if (expected_bytes.size() == 0)
            begin
                $error("read_data: unexpected beat, expected none, got 0x%02h", got);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            n_checked++;
            if (got !== want)
            begin
                $error("read_data mismatch: expected 0x%02h, got 0x%02h", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block under test.
    // ------------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = REQ_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    ldcr_scoreboard sb;

    // Idling controls. A smooth stretch offers or takes a beat every cycle.
    bit tx_smooth = 1'b0;
    bit tx_no_gap = 1'b0;
    int rx_hold_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    latched_day_clock_registers_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Offers one request beat after a random gap and returns right after the
    // edge that accepted it. Valid stays high, so a zero gap on the next call
    // keeps the stream dense without lowering and raising it in one step.
    task automatic send_item(input ldcr_req_t req, input logic [2:0] idx,
                             input logic [7:0] data, input logic [31:0] secs);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_smooth = !tx_smooth;
        gap = (tx_smooth || tx_no_gap) ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {5'd0, secs, data, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(req, idx, data, secs);
    endtask

    // Lowers valid and waits until every predicted read byte has come back.
    task automatic drain_reads();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Elapsed counts spread over the carry depths: zero, a few seconds, a few
    // hours, a few days, months, and the whole 32-bit range.
    function automatic logic [31:0] draw_seconds();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return $urandom_range(1, 120);
            2:       return $urandom_range(1, 7200);
            3:       return $urandom_range(1, 200000);
            4:       return $urandom_range(1, 50000000);
            default: return $urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls per beat, plus one long hold-off on request.
    // ------------------------------------------------------------------------
    initial
    begin : read_sink
        int  stall;
        bit  rx_smooth;
        rx_smooth = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_smooth = !rx_smooth;
            if (rx_hold_cycles > 0)
            begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
                stall = rx_smooth ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            sb.check_read(m_axis_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Request side: directed beats, then random host sessions.
    // ------------------------------------------------------------------------
    initial
    begin : request_source
        logic [2:0]  pick_idx;
        logic [7:0]  pick_data;
        logic [31:0] pick_secs;
        logic [7:0]  clock_set [NUM_REGS];
        ldcr_req_t   pick_req;
        int          random_start;
        int          n_beats;
        bit          hold_done;
        bit          drain_done;

        sb = new();
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset state, and a read above the last register.
        send_item(REQ_READ,  REG_SEC, 8'h00, 32'd0);
        send_item(REQ_READ,  3'd7,    8'h00, 32'd0);
        // Clock set to the last second of day 511, so one second overflows
        // every digit and the day count, which sets the sticky carry.
        send_item(REQ_WRITE, REG_SEC,  8'd59,  32'd0);
        send_item(REQ_WRITE, REG_MIN,  8'd59,  32'd0);
        send_item(REQ_WRITE, REG_HOUR, 8'd23,  32'd0);
        send_item(REQ_WRITE, REG_DAYL, 8'hff,  32'd0);
        send_item(REQ_WRITE, REG_DAYH, 8'h01,  32'd0);
        send_item(REQ_TICK,  REG_SEC,  8'h00,  32'd0);
        send_item(REQ_TICK,  REG_SEC,  8'h00,  32'd1);
        send_item(REQ_READ,  REG_DAYH, 8'h00,  32'd0);
        // Writes above the last register are dropped.
        send_item(REQ_WRITE, 3'd5,     8'hff,  32'hffff_ffff);
        send_item(REQ_READ,  3'd5,     8'hff,  32'hffff_ffff);
        // An out-of-range seconds value, then the largest elapsed count.
        send_item(REQ_WRITE, REG_SEC,  8'hff,  32'd0);
        send_item(REQ_TICK,  3'd7,     8'hff,  32'hffff_ffff);
        send_item(REQ_READ,  REG_SEC,  8'h00,  32'd0);
        send_item(REQ_READ,  REG_DAYH, 8'h00,  32'd0);
        // Latch snapshot, a repeated latch while set, an odd value other than
        // one from a clear flag, and an even value that clears it.
        send_item(REQ_LATCH, REG_SEC,  LATCH_ON,  32'd0);
        send_item(REQ_TICK,  REG_SEC,  8'h00,     32'd3600);
        send_item(REQ_READ,  REG_HOUR, 8'h00,     32'd0);
        send_item(REQ_LATCH, REG_SEC,  LATCH_ON,  32'd0);
        send_item(REQ_READ,  REG_HOUR, 8'h00,     32'd0);
        send_item(REQ_LATCH, REG_SEC,  LATCH_OFF, 32'd0);
        send_item(REQ_LATCH, REG_SEC,  8'h03,     32'd0);
        send_item(REQ_READ,  REG_HOUR, 8'h00,     32'd0);
        send_item(REQ_LATCH, REG_SEC,  8'hfe,     32'd0);
        send_item(REQ_READ,  REG_HOUR, 8'h00,     32'd0);

        random_start = sb.accepted;
        while (sb.accepted - random_start < RANDOM_ITEMS)
        begin
            n_beats = sb.accepted - random_start;

            // Long hold-off on the result side while reads keep coming, so
            // the pipeline fills and the request side has to stall.
            if (!hold_done && n_beats > 400)
            begin
                hold_done      = 1'b1;
                rx_hold_cycles = HOLD_CYCLES;
                tx_no_gap      = 1'b1;
                repeat (40)
                begin
                    pick_idx = 3'($urandom_range(0, 7));
                    send_item(REQ_READ, pick_idx, 8'($urandom()), $urandom());
                end
                tx_no_gap = 1'b0;
            end

            // Once, the request side goes quiet until every result is home.
            if (!drain_done && n_beats > 700)
            begin
                drain_done = 1'b1;
                drain_reads();
            end

            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // Host sets the clock: in-range digits, random high-byte flags.
                    clock_set[REG_SEC]  = 8'($urandom_range(0, 59));
                    clock_set[REG_MIN]  = 8'($urandom_range(0, 59));
                    clock_set[REG_HOUR] = 8'($urandom_range(0, 23));
                    clock_set[REG_DAYL] = 8'($urandom_range(0, 255));
                    clock_set[REG_DAYH] = 8'($urandom_range(0, 255)) & 8'hc1;
                    for (int k = 0; k < NUM_REGS; k++)
                    begin
                        pick_idx = 3'(k);
                        send_item(REQ_WRITE, pick_idx, clock_set[k], $urandom());
                    end
                end
                2, 3:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        pick_idx  = 3'($urandom_range(0, 7));
                        pick_secs = draw_seconds();
                        send_item(REQ_TICK, pick_idx, 8'($urandom()), pick_secs);
                    end
                end
                4, 5:
                begin
                    // Latched read session, with ticks that must not show
                    // through the snapshot.
                    pick_idx = 3'($urandom_range(0, 7));
                    send_item(REQ_LATCH, pick_idx, LATCH_OFF, $urandom());
                    send_item(REQ_LATCH, pick_idx, LATCH_ON, $urandom());
                    repeat ($urandom_range(1, 5))
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            pick_secs = draw_seconds();
                            send_item(REQ_TICK, pick_idx, 8'($urandom()), pick_secs);
                        end
                        pick_idx = 3'($urandom_range(0, NUM_REGS - 1));
                        send_item(REQ_READ, pick_idx, 8'($urandom()), $urandom());
                    end
                    send_item(REQ_LATCH, pick_idx, LATCH_OFF, $urandom());
                end
                6:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        pick_idx = 3'($urandom_range(0, 7));
                        send_item(REQ_READ, pick_idx, 8'($urandom()), $urandom());
                    end
                end
                7:
                begin
                    pick_idx  = 3'($urandom_range(0, 7));
                    pick_data = 8'($urandom_range(0, 255));
                    send_item(REQ_WRITE, pick_idx, pick_data, $urandom());
                end
                default:
                begin
                    // Noise: any kind, any index, any data.
                    case ($urandom_range(0, 3))
                        0:       pick_req = REQ_TICK;
                        1:       pick_req = REQ_READ;
                        2:       pick_req = REQ_WRITE;
                        default: pick_req = REQ_LATCH;
                    endcase
                    pick_idx  = 3'($urandom_range(0, 7));
                    pick_data = 8'($urandom_range(0, 255));
                    pick_secs = $urandom();
                    send_item(pick_req, pick_idx, pick_data, pick_secs);
                end
            endcase
        end

        drain_reads();
        // Tail: the pipeline is five stages deep; anything stray shows up here.
        repeat (12) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("read_data: %0d expected beats never arrived", sb.pending());
            sb.errors++;
        end

        $display("Run covered %0d ticks, %0d reads, %0d writes and %0d latch beats.",
                 sb.n_ticks, sb.n_reads, sb.n_writes, sb.n_latches);
        $display("%0d read bytes compared, %0d mismatches.", sb.n_checked, sb.errors);
        if (sb.errors == 0)
            $display("tb_latched_day_clock_registers_top: done, clean");
        else
            $display("tb_latched_day_clock_registers_top: done, errors");
        $finish;
    end

    // Watchdog: a correct run takes well under a tenth of this.
    initial
    begin : watchdog
        #1_000_000;
        $display("Timeout: the run did not complete.");
        $display("tb_latched_day_clock_registers_top: done, errors");
        $finish;
    end

endmodule

// File: latched_day_clock_registers_top.f
src/ldcr_pkg.sv
src/ldcr_split.sv
src/latched_day_clock_registers_top.sv
test/tb_latched_day_clock_registers_top.sv
